// ===== hdl/csmd_pkg.sv =====
// Shared types and constants for the chord and sticky-modifier decoder.
package csmd_pkg;

    localparam int WORD_W  = 64;
    localparam int TICK_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODIFIER_MASK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_MASK       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTOFIRE_TICKS   = 3'd4;

    localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 16'd20;
    localparam logic [TICK_W-1:0] DOUBLE_TAP_RESET = 16'd10;
    localparam logic [TICK_W-1:0] AUTOFIRE_RESET   = 16'd30;

    typedef struct packed {
        logic [WORD_W-1:0] modifier_mask;
        logic [WORD_W-1:0] chord_mask;
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] double_tap_ticks;
        logic [TICK_W-1:0] autofire_ticks;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] prev_mods;
        logic [WORD_W-1:0] sent_mods;
        logic [WORD_W-1:0] tap_waiting;
        logic [WORD_W-1:0] oneshot_mods;
        logic [WORD_W-1:0] locked_mods;
        logic [WORD_W-1:0] held_chord;
        logic              chord_active;
        logic              press_issued;
        logic              force_mod_update;
        logic [TICK_W-1:0] autofire_count;
        logic [TICK_W-1:0] tap_window_count;
        logic [TICK_W-1:0] hold_count;
    } state_t;

    typedef struct packed {
        logic              mods_valid;
        logic [WORD_W-1:0] mods_now;
        logic [WORD_W-1:0] mods_before;
        logic              chord_press;
        logic              chord_release;
        logic [WORD_W-1:0] chord_bits;
        logic              haptic_short;
        logic              haptic_long;
    } result_t;

endpackage

// ===== hdl/csmd_step.sv =====
// Combinational next-state and result logic for one button report.
module csmd_step
    import csmd_pkg::*;
(
    input  cfg_t              cfg,
    input  state_t            cur,
    input  logic [WORD_W-1:0] buttons,
    output state_t            nxt,
    output result_t           res
);

    always_comb
    begin
        state_t            s;
        logic [WORD_W-1:0] mods;
        logic [WORD_W-1:0] btn;
        logic [WORD_W-1:0] eff;
        logic [WORD_W-1:0] old_oneshot;
        logic [WORD_W-1:0] prior_sent;
        logic [WORD_W-1:0] ev_bits;
        logic              mvalid;
        logic              cpress;
        logic              crel;
        logic              rshort;
        logic              rlong;

        s           = cur;
        mods        = buttons & cfg.modifier_mask;
        btn         = buttons & cfg.chord_mask;
        prior_sent  = cur.sent_mods;
        ev_bits     = '0;
        eff         = '0;
        old_oneshot = '0;
        mvalid      = 1'b0;
        cpress      = 1'b0;
        crel        = 1'b0;
        rshort      = 1'b0;
        rlong       = 1'b0;

        // Modifier edge handling, classified by numeric compare of the words.
        if (mods != s.prev_mods || s.force_mod_update)
        begin
            s.force_mod_update = 1'b0;
            if (s.prev_mods > mods)
            begin
                s.tap_waiting      = s.prev_mods ^ mods;
                s.tap_window_count = '0;
            end
            else if (s.prev_mods < mods)
            begin
                s.hold_count = '0;
                if (((s.oneshot_mods | s.locked_mods) & mods) != '0)
                begin
                    s.oneshot_mods = s.oneshot_mods & ~mods;
                    s.locked_mods  = s.locked_mods & ~mods;
                    rlong          = 1'b1;
                end
                if ((s.tap_waiting & (mods ^ s.prev_mods)) != '0)
                begin
                    old_oneshot    = s.oneshot_mods;
                    s.oneshot_mods = s.oneshot_mods ^ (s.tap_waiting & mods);
                    s.tap_waiting  = '0;
                    if (old_oneshot != s.oneshot_mods)
                        rshort = 1'b1;
                end
            end
            eff = mods | s.oneshot_mods | s.locked_mods;
            if (eff != s.sent_mods)
            begin
                mvalid      = 1'b1;
                s.sent_mods = eff;
            end
            s.prev_mods = mods;
        end

        // A latched modifier that stays held long enough becomes locked.
        if ((mods & s.oneshot_mods) != '0)
        begin
            s.hold_count = s.hold_count + 16'd1;
            if (s.hold_count == cfg.long_press_ticks)
            begin
                s.oneshot_mods = s.oneshot_mods ^ mods;
                s.locked_mods  = s.locked_mods | mods;
                rshort         = 1'b1;
            end
        end

        if (s.tap_waiting != '0)
        begin
            s.tap_window_count = s.tap_window_count + 16'd1;
            if (s.tap_window_count >= cfg.double_tap_ticks)
                s.tap_waiting = '0;
        end

        // Chord capture, release and auto-fire.
        if (btn == '0 && s.chord_active)
        begin
            s.chord_active = 1'b0;
            if (s.held_chord != '0 && !s.press_issued)
            begin
                s.press_issued = 1'b1;
                cpress         = 1'b1;
                ev_bits        = s.held_chord;
                if (s.oneshot_mods != '0)
                begin
                    s.oneshot_mods     = '0;
                    s.force_mod_update = 1'b1;
                end
            end
            if (s.press_issued && s.held_chord != '0)
            begin
                crel    = 1'b1;
                ev_bits = s.held_chord;
            end
            s.press_issued = 1'b0;
            s.held_chord   = '0;
        end
        else if (btn != s.held_chord && !s.press_issued)
        begin
            if (s.held_chord < btn)
            begin
                s.chord_active   = 1'b1;
                s.held_chord     = btn;
                s.autofire_count = '0;
            end
        end
        else
        begin
            s.autofire_count = s.autofire_count + 16'd1;
            if (s.autofire_count >= cfg.autofire_ticks && btn != '0 && s.held_chord == btn)
            begin
                s.press_issued = 1'b1;
                cpress         = 1'b1;
                ev_bits        = btn;
                if (s.oneshot_mods != '0)
                begin
                    s.oneshot_mods     = '0;
                    s.force_mod_update = 1'b1;
                end
            end
        end

        nxt               = s;
        res.mods_valid    = mvalid;
        res.mods_now      = s.sent_mods;
        res.mods_before   = mvalid ? prior_sent : s.sent_mods;
        res.chord_press   = cpress;
        res.chord_release = crel;
        res.chord_bits    = ev_bits;
        res.haptic_short  = rshort;
        res.haptic_long   = rlong;
    end

endmodule

// ===== hdl/chord_sticky_modifier_decoder_top.sv =====
// Top level of the chord and sticky-modifier decoder: handshakes, registers and state.
// An accepted item passes through the input register, then the result register, before its
// result is on the outputs; each report gives one result.
// Throughput: one item per cycle while the consumer keeps up; the step is one combinational pass.
// Reset (rst_n low, asynchronous) clears all decoder state and both valid flags and
// returns the configuration registers to their defaults (masks zero, ticks 20/10/30).
module chord_sticky_modifier_decoder_top
    import csmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_W-1:0]    buttons,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 mods_valid,
    output logic [WORD_W-1:0]    mods_now,
    output logic [WORD_W-1:0]    mods_before,
    output logic                 chord_press,
    output logic                 chord_release,
    output logic [WORD_W-1:0]    chord_bits,
    output logic                 haptic_short,
    output logic                 haptic_long
);

    // Configuration registers. Writes must be issued only while the block is idle; the block
    // itself does not enforce this. The port can always take a write immediately.
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modifier_mask    <= '0;
            cfg_reg.chord_mask       <= '0;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.double_tap_ticks <= DOUBLE_TAP_RESET;
            cfg_reg.autofire_ticks   <= AUTOFIRE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODIFIER_MASK:    cfg_reg.modifier_mask    <= cfg_data;
                CFG_CHORD_MASK:       cfg_reg.chord_mask       <= cfg_data;
                CFG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_data[TICK_W-1:0];
                CFG_DOUBLE_TAP_TICKS: cfg_reg.double_tap_ticks <= cfg_data[TICK_W-1:0];
                CFG_AUTOFIRE_TICKS:   cfg_reg.autofire_ticks   <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register. The item held here moves into the result register, and
    // updates the decoder state, at the edge where the result register is free
    // or is being emptied. A new item is taken in the same cycle, so reports
    // stream at one per cycle while the consumer keeps up.
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_buttons_reg;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_buttons_reg <= buttons;
    end

    // Decoder state, updated once per item as it passes into the result register.
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;

    csmd_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .buttons (in_buttons_reg),
        .nxt     (state_next),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register. It holds a finished item until the consumer takes it.
    logic    out_valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_res;
    end

    assign out_valid     = out_valid_reg;
    assign mods_valid    = res_reg.mods_valid;
    assign mods_now      = res_reg.mods_now;
    assign mods_before   = res_reg.mods_before;
    assign chord_press   = res_reg.chord_press;
    assign chord_release = res_reg.chord_release;
    assign chord_bits    = res_reg.chord_bits;
    assign haptic_short  = res_reg.haptic_short;
    assign haptic_long   = res_reg.haptic_long;

    // A reported modifier change always differs from what was sent before.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mods_valid |-> mods_now != mods_before)
        else $error("modifier change reported with identical masks");

    // Every chord event names a nonzero pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (chord_press || chord_release) |-> chord_bits != '0)
        else $error("chord event with empty pattern");

    // A press can only be outstanding for a captured chord.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.press_issued |-> state_reg.held_chord != '0)
        else $error("press outstanding without a held chord");

    // The input side stalls only while an item waits in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid && !out_ready)
        else $error("input stalled without a pending item");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the chord and sticky-modifier decoder top level.
`timescale 1ns / 100ps

module tb_top
    import csmd_pkg::*;
();

    localparam int CLK_HALF     = 6;     // 12 ns clock period
    localparam int RESET_CYCLES = 7;
    localparam int MAX_WAIT     = 13;    // longest idle or stall drawn for one item
    localparam int DRAIN_CYCLES = 10;    // settle time after the last result
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before the run is abandoned
    localparam int PRINT_LIMIT  = 60;    // mismatch lines printed before going silent

    // Block ports. Every input starts at a known value at time zero.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MODIFIER_MASK;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [WORD_W-1:0]    buttons = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 mods_valid;
    logic [WORD_W-1:0]    mods_now;
    logic [WORD_W-1:0]    mods_before;
    logic                 chord_press;
    logic                 chord_release;
    logic [WORD_W-1:0]    chord_bits;
    logic                 haptic_short;
    logic                 haptic_long;

    chord_sticky_modifier_decoder_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .buttons       (buttons),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mods_valid    (mods_valid),
        .mods_now      (mods_now),
        .mods_before   (mods_before),
        .chord_press   (chord_press),
        .chord_release (chord_release),
        .chord_bits    (chord_bits),
        .haptic_short  (haptic_short),
        .haptic_long   (haptic_long)
    );

    // Our own copy of the decoder: configuration and state, updated as items are accepted.
    cfg_t   dec_cfg;
    state_t dec_state;

    // Reports waiting to be driven, and decoder events predicted but not yet seen.
    logic [WORD_W-1:0] report_queue[$];
    result_t           predicted_events[$];

    int reports_sent = 0;    // reports handed to the driver
    int reports_taken = 0;   // reports accepted by the block
    int events_seen = 0;     // results accepted from the block
    int cfg_writes = 0;      // register writes accepted
    int error_count = 0;
    int quiet_cycles = 0;

    // Handshake flags captured at the rising edge, used by the falling-edge drivers.
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    // Idle pacing for each side: runs of items either with random waits or with none.
    int tx_wait = 0;
    int tx_run = 0;
    bit tx_idle = 1'b0;
    int rx_wait = 0;
    int rx_run = 0;
    bit rx_idle = 1'b0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Draws the wait before the next item. A run of 4 to 40 items shares one mode, so long
    // back-to-back stretches are mixed at random with stretches of random gaps.
    function automatic int pick_wait(inout int run_left, inout bit idle_on);
        if (run_left == 0)
        begin
            run_left = $urandom_range(4, 40);
            idle_on = ($urandom_range(0, 2) != 0);
        end
        run_left--;
        return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    // Works out the result of one report and advances the decoder copy.
    function automatic result_t decode_report(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] mods;
        logic [WORD_W-1:0] chord;
        logic [WORD_W-1:0] shown_before;
        logic [WORD_W-1:0] latched_before;
        logic [WORD_W-1:0] effective;
        result_t r;
        r = '0;
        mods = raw & dec_cfg.modifier_mask;
        shown_before = dec_state.sent_mods;

        // Modifier edges. Press and release are told apart by comparing the words as
        // numbers, not bit by bit.
        if (mods != dec_state.prev_mods || dec_state.force_mod_update)
        begin
            dec_state.force_mod_update = 1'b0;
            if (dec_state.prev_mods > mods)
            begin
                dec_state.tap_waiting = dec_state.prev_mods ^ mods;
                dec_state.tap_window_count = '0;
            end
            else if (dec_state.prev_mods < mods)
            begin
                dec_state.hold_count = '0;
                // Pressing a latched or locked modifier drops it.
                if ((dec_state.oneshot_mods & mods) != 0
                        || (dec_state.locked_mods & mods) != 0)
                begin
                    dec_state.oneshot_mods = dec_state.oneshot_mods & ~mods;
                    dec_state.locked_mods = dec_state.locked_mods & ~mods;
                    r.haptic_long = 1'b1;
                end
                // A second tap inside the window toggles the one-shot latch.
                if ((dec_state.tap_waiting & (mods ^ dec_state.prev_mods)) != 0)
                begin
                    latched_before = dec_state.oneshot_mods;
                    dec_state.oneshot_mods = dec_state.oneshot_mods
                                             ^ (dec_state.tap_waiting & mods);
                    dec_state.tap_waiting = '0;
                    if (latched_before != dec_state.oneshot_mods)
                        r.haptic_short = 1'b1;
                end
            end
            effective = mods | dec_state.oneshot_mods | dec_state.locked_mods;
            if (effective != dec_state.sent_mods)
            begin
                r.mods_valid = 1'b1;
                dec_state.sent_mods = effective;
            end
            dec_state.prev_mods = mods;
        end

        // Holding a latched modifier long enough locks it.
        if ((mods & dec_state.oneshot_mods) != 0)
        begin
            dec_state.hold_count = dec_state.hold_count + 16'd1;
            if (dec_state.hold_count == dec_cfg.long_press_ticks)
            begin
                dec_state.oneshot_mods = dec_state.oneshot_mods ^ mods;
                dec_state.locked_mods = dec_state.locked_mods | mods;
                r.haptic_short = 1'b1;
            end
        end
        if (dec_state.tap_waiting != 0)
        begin
            dec_state.tap_window_count = dec_state.tap_window_count + 16'd1;
            if (dec_state.tap_window_count >= dec_cfg.double_tap_ticks)
                dec_state.tap_waiting = '0;
        end

        // Chords: the held pattern fires on full release, or repeatedly once it has
        // been stable long enough. Firing drops every one-shot latch.
        chord = raw & dec_cfg.chord_mask;
        if (chord == 0 && dec_state.chord_active)
        begin
            dec_state.chord_active = 1'b0;
            if (dec_state.held_chord != 0 && !dec_state.press_issued)
            begin
                dec_state.press_issued = 1'b1;
                r.chord_press = 1'b1;
                r.chord_bits = dec_state.held_chord;
                if (dec_state.oneshot_mods != 0)
                begin
                    dec_state.oneshot_mods = '0;
                    dec_state.force_mod_update = 1'b1;
                end
            end
            if (dec_state.press_issued && dec_state.held_chord != 0)
            begin
                r.chord_release = 1'b1;
                r.chord_bits = dec_state.held_chord;
            end
            dec_state.press_issued = 1'b0;
            dec_state.held_chord = '0;
        end
        else if (chord != dec_state.held_chord && !dec_state.press_issued)
        begin
            // Only a numerically larger pattern replaces the captured one.
            if (dec_state.held_chord < chord)
            begin
                dec_state.chord_active = 1'b1;
                dec_state.held_chord = chord;
                dec_state.autofire_count = '0;
            end
        end
        else
        begin
            dec_state.autofire_count = dec_state.autofire_count + 16'd1;
            if (dec_state.autofire_count >= dec_cfg.autofire_ticks && chord != 0
                    && dec_state.held_chord == chord)
            begin
                dec_state.press_issued = 1'b1;
                r.chord_press = 1'b1;
                r.chord_bits = chord;
                if (dec_state.oneshot_mods != 0)
                begin
                    dec_state.oneshot_mods = '0;
                    dec_state.force_mod_update = 1'b1;
                end
            end
        end

        r.mods_now = dec_state.sent_mods;
        r.mods_before = r.mods_valid ? shown_before : dec_state.sent_mods;
        return r;
    endfunction

    task automatic flag_mismatch(input string detail);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR at %0t: result %0d: %s", $time, events_seen, detail);
    endtask

    // Compares the result on the output ports with the oldest prediction, field by field.
    task automatic compare_event(input result_t want);
        if (mods_valid !== want.mods_valid)
            flag_mismatch($sformatf("mods_valid %b, expected %b", mods_valid, want.mods_valid));
        if (mods_now !== want.mods_now)
            flag_mismatch($sformatf("mods_now %h, expected %h", mods_now, want.mods_now));
        if (mods_before !== want.mods_before)
            flag_mismatch($sformatf("mods_before %h, expected %h", mods_before,
                                    want.mods_before));
        if (chord_press !== want.chord_press)
            flag_mismatch($sformatf("chord_press %b, expected %b", chord_press,
                                    want.chord_press));
        if (chord_release !== want.chord_release)
            flag_mismatch($sformatf("chord_release %b, expected %b", chord_release,
                                    want.chord_release));
        if (chord_bits !== want.chord_bits)
            flag_mismatch($sformatf("chord_bits %h, expected %h", chord_bits, want.chord_bits));
        if (haptic_short !== want.haptic_short)
            flag_mismatch($sformatf("haptic_short %b, expected %b", haptic_short,
                                    want.haptic_short));
        if (haptic_long !== want.haptic_long)
            flag_mismatch($sformatf("haptic_long %b, expected %b", haptic_long,
                                    want.haptic_long));
    endtask

    // Monitor: everything is sampled at the rising edge. A result is checked before the
    // item accepted at the same edge is predicted, since that item cannot have caused it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_events.size() == 0)
                    flag_mismatch("result arrived with no report outstanding");
                else
                    compare_event(predicted_events.pop_front());
                events_seen++;
            end
            if (in_valid && in_ready)
            begin
                predicted_events.push_back(decode_report(buttons));
                reports_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODIFIER_MASK:    dec_cfg.modifier_mask = cfg_data;
                    CFG_CHORD_MASK:       dec_cfg.chord_mask = cfg_data;
                    CFG_LONG_PRESS_TICKS: dec_cfg.long_press_ticks = cfg_data[TICK_W-1:0];
                    CFG_DOUBLE_TAP_TICKS: dec_cfg.double_tap_ticks = cfg_data[TICK_W-1:0];
                    CFG_AUTOFIRE_TICKS:   dec_cfg.autofire_ticks = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
                cfg_writes++;
            end
            in_taken <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;

            // Watchdog: a correct block never goes this long without some handshake.
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Report driver: presents the next queued report at the falling edge once the
    // previous one has been taken and the drawn gap has passed. A valid report is held
    // unchanged until the block accepts it.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                in_valid <= 1'b0;
            end
            else if (report_queue.size() > 0)
            begin
                buttons <= report_queue.pop_front();
                in_valid <= 1'b1;
                tx_wait = pick_wait(tx_run, tx_idle);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side: after each accepted result, ready drops for a drawn number of cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                rx_wait = pick_wait(rx_run, rx_idle);
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Queues one report. Noisy reports may get random bits outside both masks, which the
    // block must ignore.
    task automatic push_report(input logic [WORD_W-1:0] word, input bit noisy);
        logic [WORD_W-1:0] spare;
        spare = ~(dec_cfg.modifier_mask | dec_cfg.chord_mask);
        if (noisy && $urandom_range(0, 1) != 0)
            word = word | ({$urandom, $urandom} & spare);
        report_queue.push_back(word);
        reports_sent++;
    endtask

    // One random set bit of a mask, or any bit when the mask is empty.
    function automatic logic [WORD_W-1:0] pick_bit(input logic [WORD_W-1:0] mask);
        int hits[$];
        for (int i = 0; i < WORD_W; i++)
            if (mask[i])
                hits.push_back(i);
        if (hits.size() == 0)
            return 64'd1 << $urandom_range(0, WORD_W - 1);
        return 64'd1 << hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    function automatic logic [WORD_W-1:0] scatter(input int count);
        logic [WORD_W-1:0] m;
        m = '0;
        repeat (count) m = m | (64'd1 << $urandom_range(0, WORD_W - 1));
        return m;
    endfunction

    // Gesture lengths scale with the tick settings but stay short for huge ones.
    function automatic int span(input logic [TICK_W-1:0] ticks);
        return (ticks > 24) ? 24 : int'(ticks);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] data);
        int start;
        start = cfg_writes;
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        while (cfg_writes == start)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all five registers. Tick writes carry random upper bits, which must be
    // dropped since each tick register is only 16 bits wide.
    task automatic apply_setting(input logic [WORD_W-1:0] mod_mask,
                                 input logic [WORD_W-1:0] chd_mask,
                                 input logic [TICK_W-1:0] long_ticks,
                                 input logic [TICK_W-1:0] tap_ticks,
                                 input logic [TICK_W-1:0] fire_ticks);
        logic [WORD_W-1:0] word;
        write_register(CFG_MODIFIER_MASK, mod_mask);
        write_register(CFG_CHORD_MASK, chd_mask);
        word = {$urandom, $urandom};
        word[TICK_W-1:0] = long_ticks;
        write_register(CFG_LONG_PRESS_TICKS, word);
        word = {$urandom, $urandom};
        word[TICK_W-1:0] = tap_ticks;
        write_register(CFG_DOUBLE_TAP_TICKS, word);
        word = {$urandom, $urandom};
        word[TICK_W-1:0] = fire_ticks;
        write_register(CFG_AUTOFIRE_TICKS, word);
    endtask

    // Waits until every queued report is accepted and every predicted result has come.
    task automatic wait_idle();
        while (reports_taken != reports_sent || predicted_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random gestures built from the current masks: modifier taps that latch, lock and
    // get cleared again, chords that grow, shrink, auto-fire and release, and some
    // plain noise so that broken sequences appear too.
    task automatic fill_phase(input int count);
        logic [WORD_W-1:0] mm;
        logic [WORD_W-1:0] cm;
        logic [WORD_W-1:0] held;
        logic [WORD_W-1:0] tap_bits;
        logic [WORD_W-1:0] pattern;
        int stop;
        mm = dec_cfg.modifier_mask;
        cm = dec_cfg.chord_mask;
        stop = reports_sent + count;
        while (reports_sent < stop)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // Tap, release, tap again and hold; sometimes a background modifier
                    // stays down throughout, and sometimes a last press drops the latch.
                    held = ($urandom_range(0, 3) == 0) ? pick_bit(mm) : '0;
                    tap_bits = pick_bit(mm);
                    if ($urandom_range(0, 3) == 0)
                        tap_bits = tap_bits | pick_bit(mm);
                    repeat ($urandom_range(1, 2)) push_report(held | tap_bits, 1'b1);
                    repeat ($urandom_range(1, span(dec_cfg.double_tap_ticks) + 2))
                        push_report(held, 1'b1);
                    repeat ($urandom_range(1, span(dec_cfg.long_press_ticks) + 3))
                        push_report(held | tap_bits, 1'b1);
                    repeat ($urandom_range(1, 3)) push_report(held, 1'b1);
                    if ($urandom_range(0, 1) != 0)
                    begin
                        push_report(held | tap_bits, 1'b1);
                        push_report('0, 1'b1);
                    end
                end
                4, 5, 6, 7:
                begin
                    // Build a chord one button at a time, optionally with a modifier
                    // held, then hold it around the auto-fire count and let go.
                    held = ($urandom_range(0, 2) == 0) ? pick_bit(mm) : '0;
                    pattern = pick_bit(cm);
                    repeat ($urandom_range(1, 2)) push_report(held | pattern, 1'b1);
                    repeat ($urandom_range(0, 3))
                    begin
                        pattern = pattern | pick_bit(cm);
                        push_report(held | pattern, 1'b1);
                    end
                    if ($urandom_range(0, 2) == 0)
                        push_report(held | (pattern & ~pick_bit(pattern)), 1'b1);
                    repeat ($urandom_range(0, span(dec_cfg.autofire_ticks) + 4))
                        push_report(held | pattern, 1'b1);
                    if ($urandom_range(0, 2) == 0)
                        push_report(held | (pattern & (pattern - 64'd1)), 1'b1);
                    repeat ($urandom_range(1, 2)) push_report(held, 1'b1);
                end
                8: push_report(($urandom_range(0, 1) != 0) ? '1 : '0, 1'b0);
                default: repeat ($urandom_range(1, 4)) push_report({$urandom, $urandom}, 1'b0);
            endcase
        end
    endtask

    initial
    begin
        logic [WORD_W-1:0] mods_pick;
        // The decoder copy starts in its reset state.
        dec_cfg = '0;
        dec_cfg.long_press_ticks = LONG_PRESS_RESET;
        dec_cfg.double_tap_ticks = DOUBLE_TAP_RESET;
        dec_cfg.autofire_ticks = AUTOFIRE_RESET;
        dec_state = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: both masks empty, so every report is ignored.
        fill_phase(40);
        wait_idle();

        // Directed part. Modifier bits 0..3 and 63; chord bits 8..11 and 60..62; bit 3
        // belongs to both masks. Long press 3, tap window 4, auto-fire 4.
        apply_setting(64'h8000_0000_0000_000F, 64'h7000_0000_0000_0F08, 16'd3, 16'd4, 16'd4);
        push_report('0, 1'b0);
        push_report('1, 1'b0);                       // every bit set
        push_report('0, 1'b0);                       // releases the all-ones chord
        push_report(64'h1, 1'b0);                    // first tap
        push_report('0, 1'b0);
        push_report(64'h1, 1'b0);                    // second tap latches the modifier
        repeat (2) push_report(64'h1, 1'b0);         // held long enough to lock
        push_report('0, 1'b0);
        push_report(64'h1, 1'b0);                    // pressing the locked modifier drops it
        push_report('0, 1'b0);
        push_report(64'h2, 1'b0);
        repeat (4) push_report('0, 1'b0);            // tap window runs out
        push_report(64'h2, 1'b0);                    // late second tap: no latch
        push_report(64'h100, 1'b0);
        push_report(64'h300, 1'b0);                  // larger pattern is captured
        push_report(64'h200, 1'b0);                  // smaller pattern is not
        push_report('0, 1'b0);                       // press and release together
        repeat (5) push_report(64'h8, 1'b0);         // shared bit: modifier and auto-fire
        push_report('0, 1'b0);
        push_report(64'hC000_0000_0000_0000, 1'b0);  // top modifier bit with a chord bit
        push_report('0, 1'b0);
        fill_phase(260);
        wait_idle();

        // Tick values of 1, sparse masks that overlap.
        mods_pick = scatter(8);
        apply_setting(mods_pick, scatter(8) | pick_bit(mods_pick), 16'd1, 16'd1, 16'd1);
        fill_phase(240);
        wait_idle();

        // Largest values everywhere.
        apply_setting('1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        fill_phase(180);
        wait_idle();

        // Zero ticks: the tap window and auto-fire are always met; long press only on wrap.
        apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'd0, 16'd0, 16'd0);
        fill_phase(200);
        wait_idle();

        // Chords only, then modifiers only.
        apply_setting('0, scatter(10), 16'd5, 16'd3, 16'd6);
        fill_phase(120);
        wait_idle();
        apply_setting(scatter(10), '0, 16'd4, 16'd6, 16'd2);
        fill_phase(120);
        wait_idle();

        // A few mixed settings with short random tick counts.
        repeat (3)
        begin
            mods_pick = scatter($urandom_range(3, 12));
            apply_setting(mods_pick, scatter($urandom_range(3, 12)) | pick_bit(mods_pick),
                          16'($urandom_range(2, 12)), 16'($urandom_range(2, 12)),
                          16'($urandom_range(2, 12)));
            fill_phase(230);
            wait_idle();
        end

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
